// ----- hdl/spe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spe_pkg: shared types and tables of the sprite pixel extruder
// Face codes, register indexes, the face job that travels from the front end
// to the vertex sequencer, and the corner table of the six face kinds.
// ----------------------------------------------------------------------------
package spe_pkg;

   localparam int MAX_WIDTH_DEF   = 256;
   localparam int MAX_HEIGHT_DEF  = 256;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int COORD_W     = 9;
   localparam int DIM_W       = 9;
   localparam int ALPHA_W     = 8;
   localparam int NORMAL_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int FACE_COUNT  = 6;
   localparam int CORNER_W    = 3;

   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RESET  = 9'd16;
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RESET = 9'd16;
   localparam logic [ALPHA_W-1:0] SOLID_LEVEL_RESET  = 8'd128;

   // corner code bits
   localparam int CORNER_X_BIT = 0;
   localparam int CORNER_Y_BIT = 1;
   localparam int CORNER_Z_BIT = 2;

   localparam logic [2:0] VTX_LAST = 3'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SOLID_LEVEL  = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef enum logic [NORMAL_W-1:0] {
      FACE_FRONT  = 3'd0,
      FACE_BACK   = 3'd1,
      FACE_LEFT   = 3'd2,
      FACE_RIGHT  = 3'd3,
      FACE_TOP    = 3'd4,
      FACE_BOTTOM = 3'd5
   } face_type;

   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [FACE_COUNT-1:0] face_mask_type;

   // One solid pixel: its coordinates already reduced to the output width.
   typedef struct packed {
      coord_type     col;
      coord_type     y_base;   // image height minus row minus one
      coord_type     tv_base;  // row plus one
      face_mask_type faces;    // bit per face_type code
   } face_job_type;

   // Corner code of vertex vtx (two triangles, corners 0,1,2 then 0,2,3).
   function automatic logic [CORNER_W-1:0] corner_code(face_type face, logic [2:0] vtx);
      logic [1:0]            slot;
      logic [4*CORNER_W-1:0] corners;
      case (vtx)
         3'd0, 3'd3: slot = 2'd0;
         3'd1:       slot = 2'd1;
         3'd2, 3'd4: slot = 2'd2;
         default:    slot = 2'd3;
      endcase
      // packed as {corner3, corner2, corner1, corner0}
      case (face)
         FACE_FRONT:  corners = {3'd2, 3'd3, 3'd1, 3'd0};
         FACE_BACK:   corners = {3'd7, 3'd6, 3'd4, 3'd5};
         FACE_LEFT:   corners = {3'd6, 3'd2, 3'd0, 3'd4};
         FACE_RIGHT:  corners = {3'd3, 3'd7, 3'd5, 3'd1};
         FACE_TOP:    corners = {3'd6, 3'd7, 3'd3, 3'd2};
         FACE_BOTTOM: corners = {3'd5, 3'd4, 3'd0, 3'd1};
         default:     corners = '0;
      endcase
      return corners[slot*CORNER_W +: CORNER_W];
   endfunction

endpackage : spe_pkg
`default_nettype wire

// ----- hdl/spe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spe_front: request intake, solid classification and neighbour lookup
// Keeps the raster counters and three rotating one-bit line stores, and turns
// each solid pixel of the row behind the input into a face job.
// ----------------------------------------------------------------------------
module spe_front import spe_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [ALPHA_W-1:0] req_alpha,
   input  wire logic [DIM_W-1:0]   image_width,
   input  wire logic [DIM_W-1:0]   image_height,
   input  wire logic [ALPHA_W-1:0] solid_level,
   output logic                    job_valid,
   input  wire logic               job_ready,
   output face_job_type            job
);

   localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int RW         = $clog2(MAX_HEIGHT + 1);
   localparam int BANK_COUNT = 3;

   typedef logic [1:0] bank_type;
   localparam bank_type BANK_LAST = 2'd2;

   logic [WW-1:0]   width_c;
   logic [RW-1:0]   height_c;
   logic [CW-1:0]   col_ff, col_in, col_eff, hi_addr;
   logic [RW-1:0]   row_ff, row_in, row_sel;
   bank_type        cur_bank_ff, cur_bank_in, prev_bank, old_bank;
   logic [WW-1:0]   col_plus;
   logic            is_pixel, live, emit, row_end, solid_new, accept;

   logic            s1_valid_ff, s1_valid_in, s1_go;
   logic            s1_live_ff, s1_emit_ff, s1_has_left_ff, s1_right_ok_ff;
   logic            s1_top_ok_ff, s1_bottom_ff;
   logic [CW-1:0]   s1_col_ff;
   logic [RW-1:0]   s1_y_base_ff, s1_tv_base_ff;
   bank_type        s1_prev_bank_ff, s1_old_bank_ff;
   logic            prev_center_ff;

   logic [BANK_COUNT-1:0] rd_lo, rd_hi;
   logic                  center, right_solid, top_solid, left_solid;

   // clamp the dimensions to 1..max
   always_comb begin
      if (image_width == '0) begin
         width_c = WW'(1);
      end else if (int'(image_width) > MAX_WIDTH) begin
         width_c = WW'(MAX_WIDTH);
      end else begin
         width_c = WW'(image_width);
      end
      if (image_height == '0) begin
         height_c = RW'(1);
      end else if (int'(image_height) > MAX_HEIGHT) begin
         height_c = RW'(MAX_HEIGHT);
      end else begin
         height_c = RW'(image_height);
      end
   end

   assign accept    = req_valid && req_ready;
   assign col_eff   = (WW'(col_ff) >= width_c) ? '0 : col_ff;
   assign col_plus  = WW'(col_eff) + WW'(1);
   assign hi_addr   = (int'(col_plus) >= MAX_WIDTH) ? '0 : CW'(col_plus);
   assign row_end   = col_plus >= width_c;
   assign is_pixel  = (req_kind == KIND_PIXEL);
   assign solid_new = req_alpha >= solid_level;
   assign live      = is_pixel ? (row_ff < height_c) : (row_ff >= height_c);
   assign emit      = live && (!is_pixel || (row_ff != '0));
   assign row_sel   = is_pixel ? (row_ff - RW'(1)) : (height_c - RW'(1));
   assign prev_bank = (cur_bank_ff == '0) ? BANK_LAST : (cur_bank_ff - 2'd1);
   assign old_bank  = (cur_bank_ff == BANK_LAST) ? '0 : (cur_bank_ff + 2'd1);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      cur_bank_in = cur_bank_ff;
      if (accept) begin
         if (!live) begin
            col_in = col_eff;
         end else if (!row_end) begin
            col_in = CW'(col_plus);
         end else begin
            col_in = '0;
            if (is_pixel) begin
               row_in      = row_ff + RW'(1);
               cur_bank_in = (cur_bank_ff == BANK_LAST) ? '0 : (cur_bank_ff + 2'd1);
            end else begin
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         cur_bank_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         cur_bank_ff <= cur_bank_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line stores: write the current bank, read every bank at col and col+1
   for (genvar b = 0; b < BANK_COUNT; b++) begin : g_bank
      logic bank_mem [MAX_WIDTH];
      logic lo_ff, hi_ff;
      always_ff @(posedge clock) begin
         if (accept && is_pixel && live && (cur_bank_ff == bank_type'(b))) begin
            bank_mem[col_eff] <= solid_new;
         end
         if (accept) begin
            lo_ff <= bank_mem[col_eff];
            hi_ff <= bank_mem[hi_addr];
         end
      end
      assign rd_lo[b] = lo_ff;
      assign rd_hi[b] = hi_ff;
   end

   // stage one holds the item while the line store data arrives
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_live_ff      <= live;
         s1_emit_ff      <= emit;
         s1_col_ff       <= col_eff;
         s1_has_left_ff  <= col_eff != '0;
         s1_right_ok_ff  <= !row_end;
         s1_top_ok_ff    <= row_sel != '0;
         s1_bottom_ff    <= is_pixel && solid_new;
         s1_y_base_ff    <= height_c - row_sel - RW'(1);
         s1_tv_base_ff   <= row_sel + RW'(1);
         s1_prev_bank_ff <= prev_bank;
         s1_old_bank_ff  <= old_bank;
      end
      // remember this column's flag as the left neighbour of the next column
      if (s1_go && s1_live_ff) begin
         prev_center_ff <= center;
      end
   end

   assign center      = rd_lo[s1_prev_bank_ff];
   assign right_solid = s1_right_ok_ff && rd_hi[s1_prev_bank_ff];
   assign top_solid   = s1_top_ok_ff && rd_lo[s1_old_bank_ff];
   assign left_solid  = s1_has_left_ff && prev_center_ff;

   assign job_valid   = s1_valid_ff && s1_emit_ff && center;
   assign s1_go       = s1_valid_ff && (!job_valid || job_ready);
   assign req_ready   = !s1_valid_ff || s1_go;
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_comb begin
      job.col                  = coord_type'(s1_col_ff);
      job.y_base               = coord_type'(s1_y_base_ff);
      job.tv_base              = coord_type'(s1_tv_base_ff);
      job.faces                = '0;
      job.faces[FACE_FRONT]    = 1'b1;
      job.faces[FACE_BACK]     = 1'b1;
      job.faces[FACE_LEFT]     = !left_solid;
      job.faces[FACE_RIGHT]    = !right_solid;
      job.faces[FACE_TOP]      = !top_solid;
      job.faces[FACE_BOTTOM]   = !s1_bottom_ff;
   end

endmodule : spe_front
`default_nettype wire

// ----- hdl/spe_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spe_queue: face job queue
// Small first-in first-out store that lets the front end run ahead of the
// vertex sequencer.
// ----------------------------------------------------------------------------
module spe_queue import spe_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire face_job_type  push_data,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output face_job_type       pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   face_job_type  slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != NW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : spe_queue
`default_nettype wire

// ----- hdl/spe_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spe_back: vertex sequencer
// Walks the faces of one job in order, six vertices a face, one vertex per
// clock into the response register while the response port is not stalled.
// ----------------------------------------------------------------------------
module spe_back import spe_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   output logic                     job_ready,
   input  wire face_job_type        job,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [COORD_W-1:0]       rsp_x_grid,
   output logic [COORD_W-1:0]       rsp_y_grid,
   output logic                     rsp_z_back,
   output logic [COORD_W-1:0]       rsp_tex_u,
   output logic [COORD_W-1:0]       rsp_tex_v,
   output logic [NORMAL_W-1:0]      rsp_normal_dir,
   output logic                     rsp_last_vertex
);

   logic          active_ff, active_in;
   face_job_type  job_ff;
   face_mask_type mask_ff, mask_in, mask_rest;
   logic [2:0]    vtx_ff, vtx_in;
   face_type      face;
   logic [CORNER_W-1:0] code;
   logic          out_free, emit, face_done, job_last, load;
   coord_type     x_val;

   logic                rsp_valid_ff, rsp_valid_in;
   coord_type           x_ff, y_ff, u_ff, v_ff;
   logic                z_ff, last_ff;
   logic [NORMAL_W-1:0] normal_ff;

   // lowest pending face comes first
   always_comb begin
      face = FACE_FRONT;
      for (int i = FACE_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            face = face_type'(i);
         end
      end
   end

   assign code      = corner_code(face, vtx_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = active_ff && out_free;
   assign face_done = vtx_ff == VTX_LAST;
   assign mask_rest = mask_ff & ~(face_mask_type'(1) << face);
   assign job_last  = face_done && (mask_rest == '0);
   assign job_ready = !active_ff || (emit && job_last);
   assign load      = job_valid && job_ready;
   assign x_val     = job_ff.col + coord_type'(code[CORNER_X_BIT]);

   always_comb begin
      active_in = active_ff;
      mask_in   = mask_ff;
      vtx_in    = vtx_ff;
      if (load) begin
         active_in = 1'b1;
         mask_in   = job.faces;
         vtx_in    = '0;
      end else if (emit && job_last) begin
         active_in = 1'b0;
      end else if (emit) begin
         vtx_in  = face_done ? '0 : (vtx_ff + 3'd1);
         mask_in = face_done ? mask_rest : mask_ff;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      vtx_ff  <= vtx_in;
      if (load) begin
         job_ff <= job;
      end
      if (emit) begin
         x_ff      <= x_val;
         y_ff      <= job_ff.y_base + coord_type'(code[CORNER_Y_BIT]);
         z_ff      <= code[CORNER_Z_BIT];
         u_ff      <= x_val;
         v_ff      <= job_ff.tv_base - coord_type'(code[CORNER_Y_BIT]);
         normal_ff <= face;
         last_ff   <= job_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_grid      = x_ff;
   assign rsp_y_grid      = y_ff;
   assign rsp_z_back      = z_ff;
   assign rsp_tex_u       = u_ff;
   assign rsp_tex_v       = v_ff;
   assign rsp_normal_dir  = normal_ff;
   assign rsp_last_vertex = last_ff;

endmodule : spe_back
`default_nettype wire

// ----- hdl/sprite_pixel_extruder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_pixel_extruder: alpha image to extruded voxel sprite mesh
// Top level: configuration registers, front end, job queue, vertex sequencer.
// ----------------------------------------------------------------------------
// Send the alpha bytes of an image in raster order as pixel requests, then
// one flush request per column of the final row. A pixel is solid when its
// alpha is at or above the solid level register. Faces come out one row
// behind the input: each solid pixel yields a front and a back face, then a
// side face toward each non-solid neighbour (left, right, top, bottom;
// outside the image counts as non-solid). Every face is two triangles, six
// vertices, one vertex per response; rsp_last_vertex marks the final vertex
// of a request. A request may cause no vertices at all. Rate: the vertex
// sequencer emits one vertex per clock unless the response port stalls; a
// request yields 0 to 36 vertices (12 plus 6 per exposed side for a solid
// pixel); requests causing no vertices are taken one per clock while the
// queue has room. The queue holds QUEUE_DEPTH face jobs so intake keeps
// running while the sequencer works; with the sequencer idle, the first
// vertex passes stage one, the queue, the job register and the response
// register. Write the registers only between images. Width and height of
// 0 act as 1, values above the maximum act as the max.
// ----------------------------------------------------------------------------
module sprite_pixel_extruder import spe_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration write port
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_kind,
   input  wire logic [ALPHA_W-1:0]     req_alpha,
   // response channel, one vertex per response
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COORD_W-1:0]          rsp_x_grid,
   output logic [COORD_W-1:0]          rsp_y_grid,
   output logic                        rsp_z_back,
   output logic [COORD_W-1:0]          rsp_tex_u,
   output logic [COORD_W-1:0]          rsp_tex_v,
   output logic [NORMAL_W-1:0]         rsp_normal_dir,
   output logic                        rsp_last_vertex
);

   logic [DIM_W-1:0]   image_width_ff, image_width_in;
   logic [DIM_W-1:0]   image_height_ff, image_height_in;
   logic [ALPHA_W-1:0] solid_level_ff, solid_level_in;

   logic         fe_job_valid, fe_job_ready;
   face_job_type fe_job;
   logic         q_job_valid, q_job_ready;
   face_job_type q_job;

   // register writes land immediately; unknown indexes are dropped
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      solid_level_in  = solid_level_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            CSR_SOLID_LEVEL:  solid_level_in  = csr_wdata[ALPHA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         solid_level_ff  <= SOLID_LEVEL_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         solid_level_ff  <= solid_level_in;
      end
   end

   // front end: counters, line stores, neighbour lookup
   spe_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_alpha    (req_alpha),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .solid_level  (solid_level_ff),
      .job_valid    (fe_job_valid),
      .job_ready    (fe_job_ready),
      .job          (fe_job)
   );

   // decouple intake from vertex emission
   spe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_job_valid),
      .push_ready (fe_job_ready),
      .push_data  (fe_job),
      .pop_valid  (q_job_valid),
      .pop_ready  (q_job_ready),
      .pop_data   (q_job)
   );

   // back end: face walk and response register
   spe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_job_valid),
      .job_ready       (q_job_ready),
      .job             (q_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_grid      (rsp_x_grid),
      .rsp_y_grid      (rsp_y_grid),
      .rsp_z_back      (rsp_z_back),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_normal_dir  (rsp_normal_dir),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule : sprite_pixel_extruder
`default_nettype wire

// ----- hdl/spe_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spe_checker: port-level checks of the sprite pixel extruder
// Watches the top level's ports and flags broken request and response
// sequencing.
// ----------------------------------------------------------------------------
module spe_checker import spe_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   req_kind,
   input wire logic [ALPHA_W-1:0]     req_alpha,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [COORD_W-1:0]     rsp_x_grid,
   input wire logic [COORD_W-1:0]     rsp_y_grid,
   input wire logic                   rsp_z_back,
   input wire logic [COORD_W-1:0]     rsp_tex_u,
   input wire logic [COORD_W-1:0]     rsp_tex_v,
   input wire logic [NORMAL_W-1:0]    rsp_normal_dir,
   input wire logic                   rsp_last_vertex
);

   // reset empties the response register
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a waiting request holds
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_kind) && $stable(req_alpha))
      else $error("waiting request changed");

   // a stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_grid)
         && $stable(rsp_y_grid) && $stable(rsp_z_back) && $stable(rsp_tex_u)
         && $stable(rsp_tex_v) && $stable(rsp_normal_dir) && $stable(rsp_last_vertex))
      else $error("stalled response changed");

   // within one request the vertices follow without a gap
   a_no_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_vertex |=> rsp_valid)
      else $error("gap inside a request's vertex run");

   // a solid pixel always ends after its back face at the earliest
   a_last_not_front : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_vertex |-> rsp_normal_dir != FACE_FRONT)
      else $error("request ended on the front face");

endmodule : spe_checker

bind sprite_pixel_extruder spe_checker u_checker (.*);
`default_nettype wire

// ----- bench/sprite_pixel_extruder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_extruder_tb: self-checking bench of the sprite pixel extruder
// Streams alpha images in raster order plus their flush requests, predicts
// every mesh vertex in a scoreboard with its own line stores, and compares
// each returned vertex field by field under random idling on both channels.
// ----------------------------------------------------------------------------
import spe_pkg::*;

typedef struct packed {
   logic [COORD_W-1:0]  x_grid;
   logic [COORD_W-1:0]  y_grid;
   logic                z_back;
   logic [COORD_W-1:0]  tex_u;
   logic [COORD_W-1:0]  tex_v;
   logic [NORMAL_W-1:0] normal_dir;
   logic                last_vertex;
} mesh_vertex_type;

class vertex_scoreboard;
   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   logic [ALPHA_W-1:0] threshold_reg;
   bit                 older_solid    [MAX_WIDTH_DEF];
   bit                 previous_solid [MAX_WIDTH_DEF];
   bit                 current_solid  [MAX_WIDTH_DEF];
   int unsigned        column;
   int unsigned        row;
   mesh_vertex_type    expected_q [$];
   int unsigned        errors;
   int unsigned        vertices_checked;
   int unsigned        ignored_requests;
   int unsigned        face_count [FACE_COUNT];
   // corner codes of both triangles per face: bit0 x+1, bit1 upper edge, bit2 back
   bit [2:0]           face_path [FACE_COUNT][6] = '{
      '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2},
      '{3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7},
      '{3'd4, 3'd0, 3'd2, 3'd4, 3'd2, 3'd6},
      '{3'd1, 3'd5, 3'd7, 3'd1, 3'd7, 3'd3},
      '{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
      '{3'd1, 3'd0, 3'd4, 3'd1, 3'd4, 3'd5}};

   function new();
      width_reg     = IMAGE_WIDTH_RESET;
      height_reg    = IMAGE_HEIGHT_RESET;
      threshold_reg = SOLID_LEVEL_RESET;
      column        = 0;
      row           = 0;
   endfunction

   function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg = data;
         CSR_IMAGE_HEIGHT: height_reg = data;
         CSR_SOLID_LEVEL:  threshold_reg = data[ALPHA_W-1:0];
         default: ;
      endcase
   endfunction

   function int unsigned fit_dim(int unsigned value, int unsigned limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function void add_face(face_type face, int unsigned c, int unsigned r, int unsigned h);
      mesh_vertex_type v;
      bit [2:0]        code;
      int unsigned     x;
      int unsigned     y;
      int unsigned     tv;
      int              k;
      for (k = 0; k < 6; k++) begin
         code          = face_path[int'(face)][k];
         x             = c + code[0];
         y             = h - r - 1 + code[1];
         tv            = r + 1 - code[1];
         v.x_grid      = x[COORD_W-1:0];
         v.y_grid      = y[COORD_W-1:0];
         v.z_back      = code[2];
         v.tex_u       = x[COORD_W-1:0];
         v.tex_v       = tv[COORD_W-1:0];
         v.normal_dir  = face;
         v.last_vertex = 1'b0;
         expected_q.insert(expected_q.size(), v);
      end
      face_count[int'(face)]++;
   endfunction

   function void add_cell(int unsigned c, int unsigned r, int unsigned w, int unsigned h,
                          bit bottom_solid);
      bit left_solid;
      bit right_solid;
      bit top_solid;
      left_solid  = (c >= 1) && previous_solid[c - 1];
      right_solid = (c + 1 < w) && previous_solid[c + 1];
      top_solid   = (r >= 1) && older_solid[c];
      add_face(FACE_FRONT, c, r, h);
      add_face(FACE_BACK, c, r, h);
      if (!left_solid) add_face(FACE_LEFT, c, r, h);
      if (!right_solid) add_face(FACE_RIGHT, c, r, h);
      if (!top_solid) add_face(FACE_TOP, c, r, h);
      if (!bottom_solid) add_face(FACE_BOTTOM, c, r, h);
   endfunction

   // Advance the mesh state by one accepted request and queue its vertices.
   function void note_request(kind_type kind, logic [ALPHA_W-1:0] alpha);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned queued;
      bit          solid;
      w      = fit_dim(width_reg, MAX_WIDTH_DEF);
      h      = fit_dim(height_reg, MAX_HEIGHT_DEF);
      queued = expected_q.size();
      // width lowered mid-row: restart the row
      if (column >= w) column = 0;
      c = column;
      if (kind == KIND_PIXEL) begin
         if (row >= h) begin
            ignored_requests++;
            return;
         end
         solid = (alpha >= threshold_reg);
         current_solid[c] = solid;
         if (row >= 1 && previous_solid[c]) add_cell(c, row - 1, w, h, solid);
         if (c + 1 >= w) begin
            column         = 0;
            row            = row + 1;
            older_solid    = previous_solid;
            previous_solid = current_solid;
         end else begin
            column = c + 1;
         end
      end else begin
         if (row < h) begin
            ignored_requests++;
            return;
         end
         if (previous_solid[c]) add_cell(c, h - 1, w, h, 1'b0);
         if (c + 1 >= w) begin
            column = 0;
            row    = 0;
         end else begin
            column = c + 1;
         end
      end
      if (expected_q.size() > queued) expected_q[expected_q.size() - 1].last_vertex = 1'b1;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   task report_mismatch(string what);
      $display("[%0t] ERROR vertex %0d: %s", $realtime, vertices_checked, what);
      errors++;
   endtask

   task check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   task check_vertex(mesh_vertex_type got);
      mesh_vertex_type want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("unexpected vertex x=%0d y=%0d normal=%0d",
                                   got.x_grid, got.y_grid, got.normal_dir));
      end else begin
         want = expected_q.pop_front();
         check_field("x_grid", got.x_grid, want.x_grid);
         check_field("y_grid", got.y_grid, want.y_grid);
         check_field("z_back", got.z_back, want.z_back);
         check_field("tex_u", got.tex_u, want.tex_u);
         check_field("tex_v", got.tex_v, want.tex_v);
         check_field("normal_dir", got.normal_dir, want.normal_dir);
         check_field("last_vertex", got.last_vertex, want.last_vertex);
      end
      vertices_checked++;
   endtask
endclass

module sprite_pixel_extruder_tb;

   localparam int STALL_LIMIT   = 4000;  // cycles without any handshake or register write
   localparam int SETTLE_CYCLES = 24;    // queue depth plus pipeline, with margin
   localparam int END_CYCLES    = 40;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_kind;
   logic [ALPHA_W-1:0]     req_alpha;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [COORD_W-1:0]     rsp_x_grid;
   logic [COORD_W-1:0]     rsp_y_grid;
   logic                   rsp_z_back;
   logic [COORD_W-1:0]     rsp_tex_u;
   logic [COORD_W-1:0]     rsp_tex_v;
   logic [NORMAL_W-1:0]    rsp_normal_dir;
   logic                   rsp_last_vertex;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cur_threshold;
   int unsigned requests_sent;
   int unsigned images_sent;
   int          quiet_cycles;

   vertex_scoreboard mesh_sb;

   sprite_pixel_extruder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_alpha       (req_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_grid      (rsp_x_grid),
      .rsp_y_grid      (rsp_y_grid),
      .rsp_z_back      (rsp_z_back),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_normal_dir  (rsp_normal_dir),
      .rsp_last_vertex (rsp_last_vertex)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check each accepted vertex, then pick next cycle's stall for the receiver.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mesh_sb.check_vertex({rsp_x_grid, rsp_y_grid, rsp_z_back, rsp_tex_u, rsp_tex_v,
                               rsp_normal_dir, rsp_last_vertex});
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("sprite_pixel_extruder verification failed");
         $finish;
      end
   end

   // Present one request, hold it until taken, then let the scoreboard see it.
   task automatic send_request(kind_type kind, logic [ALPHA_W-1:0] alpha);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_alpha <= alpha;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mesh_sb.note_request(kind, alpha);
      requests_sent++;
   endtask

   // Drop valid, drain every pending vertex, then let silent requests retire.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mesh_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back once the block is idle.
   task automatic write_config(int unsigned w_reg, int unsigned h_reg, int unsigned thr);
      logic [CSR_DATA_W-1:0] thr_word;
      thr_word = {1'($urandom_range(1)), 8'(thr)};  // top bit is don't-care
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_IMAGE_WIDTH;
      csr_wdata    <= 9'(w_reg);
      mesh_sb.set_register(CSR_IMAGE_WIDTH, 9'(w_reg));
      @(posedge clock);
      csr_index    <= CSR_IMAGE_HEIGHT;
      csr_wdata    <= 9'(h_reg);
      mesh_sb.set_register(CSR_IMAGE_HEIGHT, 9'(h_reg));
      @(posedge clock);
      csr_index    <= CSR_SOLID_LEVEL;
      csr_wdata    <= thr_word;
      mesh_sb.set_register(CSR_SOLID_LEVEL, thr_word);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_threshold = thr;
   endtask

   // Alpha with a given share of solid pixels, biased toward the threshold edge.
   function automatic logic [ALPHA_W-1:0] pick_alpha(int unsigned density);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return 8'($urandom_range(255));
      if (roll < 14 && cur_threshold > 0) return 8'(roll[0] ? cur_threshold : cur_threshold - 1);
      if ($urandom_range(99) < density) return 8'($urandom_range(255, cur_threshold));
      if (cur_threshold == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(cur_threshold - 1, 0));
   endfunction

   // One whole image plus its flush row; noise adds early flushes and late pixels.
   task automatic send_image(int unsigned cols, int unsigned rows, int unsigned density,
                             bit noisy);
      int unsigned r;
      int unsigned c;
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            if (noisy && $urandom_range(19) == 0)
               send_request(KIND_FLUSH, 8'($urandom_range(255)));
            send_request(KIND_PIXEL, pick_alpha(density));
         end
      end
      if (noisy)
         repeat ($urandom_range(2, 1)) send_request(KIND_PIXEL, 8'($urandom_range(255)));
      for (c = 0; c < cols; c++) send_request(KIND_FLUSH, 8'($urandom_range(255)));
      images_sent++;
   endtask

   // Small random images; each setting holds for one to three images in a row.
   task automatic run_random_phase(int unsigned budget);
      int unsigned sent;
      int unsigned cols;
      int unsigned rows;
      int unsigned w_reg;
      int unsigned h_reg;
      int unsigned thr;
      sent = 0;
      while (sent < budget) begin
         cols  = ($urandom_range(4) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
         rows  = ($urandom_range(5) == 0) ? $urandom_range(9, 5) : $urandom_range(4, 1);
         w_reg = (cols == 1 && $urandom_range(1) == 1) ? 0 : cols;
         h_reg = (rows == 1 && $urandom_range(1) == 1) ? 0 : rows;
         case ($urandom_range(7))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(255);
         endcase
         write_config(w_reg, h_reg, thr);
         repeat ($urandom_range(3, 1)) begin
            if (sent < budget) begin
               send_image(cols, rows, $urandom_range(95, 15), $urandom_range(3) == 0);
               sent += cols * (rows + 1);
            end
         end
      end
   endtask

   initial begin
      mesh_sb       = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      cur_threshold = SOLID_LEVEL_RESET;
      requests_sent = 0;
      images_sent   = 0;
      quiet_cycles  = 0;
      reset        <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_IMAGE_WIDTH;
      csr_wdata    <= '0;
      req_valid    <= 1'b0;
      req_kind     <= KIND_PIXEL;
      req_alpha    <= '0;
      rsp_ready    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 3x2 image with an isolated pixel, alpha extremes and the
      // threshold edge, a flush before the image is complete and a pixel after.
      write_config(3, 2, 128);
      send_request(KIND_FLUSH, 8'hFF);
      send_request(KIND_PIXEL, 8'd255);
      send_request(KIND_PIXEL, 8'd0);
      send_request(KIND_PIXEL, 8'd128);
      send_request(KIND_PIXEL, 8'd127);
      send_request(KIND_PIXEL, 8'd255);
      send_request(KIND_PIXEL, 8'd255);
      send_request(KIND_PIXEL, 8'd0);
      repeat (3) send_request(KIND_FLUSH, 8'($urandom_range(255)));
      images_sent++;

      // Directed: lower the width in mid-row so the column count restarts.
      write_config(3, 2, 1);
      send_request(KIND_PIXEL, 8'd200);
      send_request(KIND_PIXEL, 8'd0);
      send_request(KIND_PIXEL, 8'd9);
      send_request(KIND_PIXEL, 8'd1);
      send_request(KIND_PIXEL, 8'd0);
      write_config(1, 2, 1);
      send_request(KIND_PIXEL, 8'd77);
      send_request(KIND_FLUSH, 8'h5A);
      images_sent++;

      // Directed: zero width and height act as one; zero threshold makes all solid.
      write_config(0, 0, 0);
      send_request(KIND_PIXEL, 8'd0);
      send_request(KIND_FLUSH, 8'h00);
      images_sent++;

      // Directed: top threshold.
      write_config(2, 1, 255);
      send_request(KIND_PIXEL, 8'd254);
      send_request(KIND_PIXEL, 8'd255);
      repeat (2) send_request(KIND_FLUSH, 8'($urandom_range(255)));
      images_sent++;

      // Phase one: sender mostly busy, receiver stalls a lot.
      send_idle_pct = 10;
      recv_idle_pct = 70;
      run_random_phase(20);

      // Phase two: sender idles a lot, receiver rarely stalls.
      send_idle_pct = 70;
      recv_idle_pct = 10;
      run_random_phase(20);

      // Phase three: full rate on both sides, then the tallest image, with a
      // zero width and a height above the maximum.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(20);
      write_config(0, 511, $urandom_range(200, 40));
      send_image(1, MAX_HEIGHT_DEF, 55, 1'b0);

      // Drain, then give late or stray vertices a chance to show up.
      req_valid <= 1'b0;
      while (mesh_sb.pending() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("Summary: %0d requests (%0d ignored) in %0d images, %0d vertices checked",
               requests_sent, mesh_sb.ignored_requests, images_sent,
               mesh_sb.vertices_checked);
      $display("Summary: faces front %0d back %0d left %0d right %0d top %0d bottom %0d",
               mesh_sb.face_count[FACE_FRONT], mesh_sb.face_count[FACE_BACK],
               mesh_sb.face_count[FACE_LEFT], mesh_sb.face_count[FACE_RIGHT],
               mesh_sb.face_count[FACE_TOP], mesh_sb.face_count[FACE_BOTTOM]);
      if (mesh_sb.errors == 0)
         $display("sprite_pixel_extruder verification clean");
      else
         $display("sprite_pixel_extruder verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/spe_pkg.sv
hdl/spe_front.sv
hdl/spe_queue.sv
hdl/spe_back.sv
hdl/sprite_pixel_extruder.sv
hdl/spe_checker.sv
bench/sprite_pixel_extruder_tb.sv
